// ===== design/multi_node_heartbeat_monitor_defines.svh =====
// Assertion macros shared by the heartbeat monitor modules.
`ifndef MULTI_NODE_HEARTBEAT_MONITOR_DEFINES_SVH
`define MULTI_NODE_HEARTBEAT_MONITOR_DEFINES_SVH

// Same-cycle implication, checked on clk and held off while rst_n is low.
`define MNHB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and held off while rst_n is low.
`define MNHB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mnhb_pkg.sv =====
// Types, constants and helpers shared by the heartbeat monitor modules.
package mnhb_pkg;

  // Number of monitored nodes; the result masks show the first three.
  localparam int NODE_COUNT = 3;
  localparam int MASK_W     = 3;

  // Saturation limits and status byte decode values.
  localparam logic [15:0] SILENCE_MAX   = 16'hFFFF;
  localparam logic [7:0]  COUNT_MAX     = 8'hFF;
  localparam logic [3:0]  MODE_DEGRADED = 4'h2;
  localparam logic [3:0]  MODE_LIMP     = 4'h3;
  localparam logic [2:0]  MULTI_FAULT   = 3'd2;
  localparam int          BRAKE_BIT     = 1;

  // Register reset values.
  localparam logic [15:0] TIMEOUT_RST  = 16'd15;
  localparam logic [7:0]  CONFIRM_RST  = 8'd5;
  localparam logic [7:0]  RECOVERY_RST = 8'd3;
  localparam logic [15:0] GRACE_RST    = 16'd100;
  localparam logic [7:0]  DEGRADED_RST = 8'd10;
  localparam logic [7:0]  ESCALATE_RST = 8'd5;
  localparam logic [2:0]  BRAKE_RST    = 3'd1;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_ARRIVAL = 2'd1,
    ACT_CHECK   = 2'd2,
    ACT_UNUSED  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    REG_TIMEOUT    = 3'd0,
    REG_CONFIRM    = 3'd1,
    REG_RECOVERY   = 3'd2,
    REG_GRACE      = 3'd3,
    REG_DEGRADED   = 3'd4,
    REG_ESCALATE   = 3'd5,
    REG_BRAKE_NODE = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    action_t     action;
    logic [2:0]  node_index;
    logic [7:0]  status_byte;
  } mnhb_in_t;

  typedef struct packed {
    logic [2:0] timed_out_mask;
    logic [2:0] confirmed_mask;
    logic       any_confirmed;
    logic [2:0] content_fault_mask;
    logic       brake_fault;
    logic       grace_active;
  } mnhb_out_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [7:0]  confirm_ticks;
    logic [7:0]  recovery_needed;
    logic [7:0]  degraded_limit;
    logic [7:0]  escalate_limit;
    logic [2:0]  brake_node;
  } cfg_t;

  // Per-node command decoded from one request.
  typedef struct packed {
    logic       tick;
    logic       arrival;
    logic       check;
    logic [7:0] status_byte;
  } node_cmd_t;

  // Per-node flags that feed the result.
  typedef struct packed {
    logic timed_out;
    logic confirmed;
    logic content_fault;
    logic brake_bit;
  } node_flags_t;

  function automatic logic [7:0] sat_inc8(input logic [7:0] v);
    return (v != COUNT_MAX) ? v + 8'd1 : v;
  endfunction

endpackage

// ===== design/mnhb_cfg.sv =====
// Configuration registers and the startup grace counter.
module mnhb_cfg import mnhb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [15:0] wr_data,
  input  logic        tick_adv,
  output cfg_t        cfg,
  output logic        grace_zero,
  output logic        grace_active_nxt
);

  cfg_t        cfg_r, cfg_nxt;
  logic [15:0] grace_r, grace_nxt;

  // Register writes and the grace countdown; a grace write also reloads the countdown.
  always_comb begin
    cfg_nxt   = cfg_r;
    grace_nxt = grace_r;
    if (tick_adv && (grace_r != 16'd0)) begin
      grace_nxt = grace_r - 16'd1;
    end
    if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_TIMEOUT:    cfg_nxt.timeout_ticks   = wr_data;
        REG_CONFIRM:    cfg_nxt.confirm_ticks   = wr_data[7:0];
        REG_RECOVERY:   cfg_nxt.recovery_needed = wr_data[7:0];
        REG_GRACE:      grace_nxt               = wr_data;
        REG_DEGRADED:   cfg_nxt.degraded_limit  = wr_data[7:0];
        REG_ESCALATE:   cfg_nxt.escalate_limit  = wr_data[7:0];
        REG_BRAKE_NODE: cfg_nxt.brake_node      = wr_data[2:0];
        default:        cfg_nxt                 = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ticks   <= TIMEOUT_RST;
      cfg_r.confirm_ticks   <= CONFIRM_RST;
      cfg_r.recovery_needed <= RECOVERY_RST;
      cfg_r.degraded_limit  <= DEGRADED_RST;
      cfg_r.escalate_limit  <= ESCALATE_RST;
      cfg_r.brake_node      <= BRAKE_RST;
      grace_r               <= GRACE_RST;
    end else begin
      cfg_r   <= cfg_nxt;
      grace_r <= grace_nxt;
    end
  end

  assign cfg              = cfg_r;
  assign grace_zero       = (grace_r == 16'd0);
  assign grace_active_nxt = (grace_nxt != 16'd0);

endmodule

// ===== design/mnhb_node.sv =====
// State and update logic of one monitored node.
`include "multi_node_heartbeat_monitor_defines.svh"

module mnhb_node import mnhb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  node_cmd_t   cmd,
  input  cfg_t        cfg,
  output node_flags_t flags_nxt
);

  logic [15:0] silence_r, silence_nxt;
  logic        timed_out_r, timed_out_nxt;
  logic [7:0]  confirm_r, confirm_nxt;
  logic        confirmed_r, confirmed_nxt;
  logic [7:0]  recovery_r, recovery_nxt;
  logic [7:0]  degraded_r, degraded_nxt;
  logic [7:0]  escalate_r, escalate_nxt;
  logic        content_fault_r, content_fault_nxt;
  logic [3:0]  fault_bits_r, fault_bits_nxt;

  // Next-state logic for tick, arrival and content check.
  always_comb begin
    logic [15:0] sil_inc;
    logic [7:0]  cc_inc;
    logic [7:0]  rc_inc;
    logic [3:0]  mode;
    logic [3:0]  faults;
    logic [2:0]  fault_cnt;

    silence_nxt       = silence_r;
    timed_out_nxt     = timed_out_r;
    confirm_nxt       = confirm_r;
    confirmed_nxt     = confirmed_r;
    recovery_nxt      = recovery_r;
    degraded_nxt      = degraded_r;
    escalate_nxt      = escalate_r;
    content_fault_nxt = content_fault_r;
    fault_bits_nxt    = fault_bits_r;

    sil_inc   = (silence_r != SILENCE_MAX) ? silence_r + 16'd1 : silence_r;
    cc_inc    = sat_inc8(confirm_r);
    rc_inc    = sat_inc8(recovery_r);
    mode      = cmd.status_byte[3:0];
    faults    = cmd.status_byte[7:4];
    fault_cnt = 3'($countones(faults));

    if (en && cmd.tick && !confirmed_r) begin
      // Silence grows; at the timeout the node is marked, then confirmation counts.
      silence_nxt = sil_inc;
      if (sil_inc >= cfg.timeout_ticks) begin
        if (!timed_out_r) begin
          timed_out_nxt = 1'b1;
          confirm_nxt   = 8'd0;
        end else begin
          recovery_nxt = 8'd0;
          confirm_nxt  = cc_inc;
          if (cc_inc >= cfg.confirm_ticks) begin
            confirmed_nxt = 1'b1;
          end
        end
      end
    end else if (en && cmd.arrival) begin
      // A heartbeat clears silence and may cancel an unconfirmed timeout.
      silence_nxt = 16'd0;
      if (!confirmed_r && timed_out_r) begin
        if (rc_inc >= cfg.recovery_needed) begin
          timed_out_nxt = 1'b0;
          confirm_nxt   = 8'd0;
          recovery_nxt  = 8'd0;
        end else begin
          recovery_nxt = rc_inc;
        end
      end
    end else if (en && cmd.check) begin
      // Content check: run lengths of degraded modes and multi-bit faults.
      fault_bits_nxt = faults;
      degraded_nxt   = ((mode == MODE_DEGRADED) || (mode == MODE_LIMP)) ?
                       sat_inc8(degraded_r) : 8'd0;
      escalate_nxt   = (fault_cnt >= MULTI_FAULT) ? sat_inc8(escalate_r) : 8'd0;
      if ((degraded_nxt >= cfg.degraded_limit) || (escalate_nxt >= cfg.escalate_limit)) begin
        content_fault_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      silence_r       <= 16'd0;
      timed_out_r     <= 1'b0;
      confirm_r       <= 8'd0;
      confirmed_r     <= 1'b0;
      recovery_r      <= 8'd0;
      degraded_r      <= 8'd0;
      escalate_r      <= 8'd0;
      content_fault_r <= 1'b0;
      fault_bits_r    <= 4'd0;
    end else begin
      silence_r       <= silence_nxt;
      timed_out_r     <= timed_out_nxt;
      confirm_r       <= confirm_nxt;
      confirmed_r     <= confirmed_nxt;
      recovery_r      <= recovery_nxt;
      degraded_r      <= degraded_nxt;
      escalate_r      <= escalate_nxt;
      content_fault_r <= content_fault_nxt;
      fault_bits_r    <= fault_bits_nxt;
    end
  end

  assign flags_nxt.timed_out     = timed_out_nxt;
  assign flags_nxt.confirmed     = confirmed_nxt;
  assign flags_nxt.content_fault = content_fault_nxt;
  assign flags_nxt.brake_bit     = fault_bits_nxt[BRAKE_BIT];

  // A confirmed fault stays latched until reset.
  `MNHB_ASSERT_NXT(a_confirmed_latched, confirmed_r, confirmed_r, "confirmed fault was cleared")
  // A content fault stays latched until reset.
  `MNHB_ASSERT_NXT(a_content_latched, content_fault_r, content_fault_r, "content fault was cleared")
  // Confirmation is only reached from the timed-out state, which it then freezes.
  `MNHB_ASSERT_IMP(a_confirmed_timed_out, confirmed_r, timed_out_r, "confirmed without timeout")

endmodule

// ===== design/multi_node_heartbeat_monitor.sv =====
// Heartbeat monitor top level: request register, node updates, result register.
// The block takes one request per clock while in_stall is low. Each request is held
// in the request register until the result register is free; then every node updates
// in parallel and the result is loaded into the result register. out_stall holds the
// result register; in_stall rises only when a request waits behind a stalled result.
// Configuration writes are always ready and must be issued while no request is
// in flight; a grace_ticks write also reloads the startup grace countdown.
`include "multi_node_heartbeat_monitor_defines.svh"

module multi_node_heartbeat_monitor import mnhb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  mnhb_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output mnhb_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic        s1_valid_r, s1_valid_nxt;
  mnhb_in_t    s1_data_r;
  logic        out_valid_r, out_valid_nxt;
  mnhb_out_t   out_data_r, out_data_nxt;
  logic        accept;
  logic        advance;
  logic        is_tick;
  cfg_t        cfg;
  logic        grace_zero;
  logic        grace_active_nxt;
  node_cmd_t   node_cmd [NODE_COUNT];
  node_flags_t node_flags [NODE_COUNT];

  // Handshake: the request moves on whenever the result register is free.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_tick  = (s1_data_r.action == ACT_TICK);

  assign cfg_ready = 1'b1;

  mnhb_cfg u_cfg (
    .clk              (clk),
    .rst_n            (rst_n),
    .wr_en            (cfg_valid),
    .wr_index         (cfg_index),
    .wr_data          (cfg_data),
    .tick_adv         (advance && is_tick),
    .cfg              (cfg),
    .grace_zero       (grace_zero),
    .grace_active_nxt (grace_active_nxt)
  );

  // One node instance per monitored node; out-of-range indices match none.
  for (genvar n = 0; n < NODE_COUNT; n++) begin : g_node
    assign node_cmd[n].tick        = is_tick && grace_zero;
    assign node_cmd[n].arrival     = (s1_data_r.action == ACT_ARRIVAL) &&
                                     (s1_data_r.node_index == 3'(n));
    assign node_cmd[n].check       = (s1_data_r.action == ACT_CHECK) &&
                                     (s1_data_r.node_index == 3'(n));
    assign node_cmd[n].status_byte = s1_data_r.status_byte;

    mnhb_node u_node (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (advance),
      .cmd       (node_cmd[n]),
      .cfg       (cfg),
      .flags_nxt (node_flags[n])
    );
  end

  // Result assembly from the updated node state.
  always_comb begin
    out_data_nxt = '0;
    for (int n = 0; n < NODE_COUNT; n++) begin
      if (n < MASK_W) begin
        out_data_nxt.timed_out_mask[n]     = node_flags[n].timed_out;
        out_data_nxt.confirmed_mask[n]     = node_flags[n].confirmed;
        out_data_nxt.content_fault_mask[n] = node_flags[n].content_fault;
      end
      if (node_flags[n].confirmed) begin
        out_data_nxt.any_confirmed = 1'b1;
      end
      if (cfg.brake_node == 3'(n)) begin
        out_data_nxt.brake_fault = node_flags[n].brake_bit;
      end
    end
    out_data_nxt.grace_active = grace_active_nxt;
  end

  // Valid flags for the request and result registers.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = advance || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A request that moves on always lands in the result register.
  `MNHB_ASSERT_NXT(a_advance_lands, advance, out_valid_r, "advanced request lost")
  // Input stall only when a request is actually held.
  `MNHB_ASSERT_IMP(a_stall_held, in_stall, s1_valid_r && out_valid_r, "stall without held request")
  // With all nodes visible, the any flag matches the confirmed mask.
  `MNHB_ASSERT_IMP(a_any_matches, out_valid_r,
    (NODE_COUNT > MASK_W) || (out_data_r.any_confirmed == (|out_data_r.confirmed_mask)),
    "any_confirmed disagrees with confirmed_mask")

endmodule
